### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is low
`define MP2D_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property, also checked while reset is low
`define MP2D_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### hw/rtl/mp2d_pkg.sv
// shared widths, register codes, reset values and state types of the max pooling block
// no dependencies
package mp2d_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int IW_W      = 9;
    localparam int IH_W      = 11;
    localparam int POOL_W    = 4;
    localparam int STRIDE_W  = 4;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_POOL   = 8;

    localparam int RST_IMAGE_WIDTH  = 64;
    localparam int RST_IMAGE_HEIGHT = 64;
    localparam int RST_POOL_SIZE    = 2;
    localparam int RST_STRIDE       = 2;
    localparam int RST_PHASE        = (RST_POOL_SIZE - 1) % RST_STRIDE;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_POOL_SIZE,
        REG_STRIDE
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WRITE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        JOB_COL_S,
        JOB_ROW_S,
        JOB_ROW_P,
        JOB_PHASE
    } t_mod_job;

endpackage

### hw/rtl/mp2d_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module mp2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/streaming_max_pooling_2d_top.sv
// a word is accepted, then written to the row store; a word that closes a window then reads
// its p*p samples through the row store read port and waits for the output register
// the first word after a config write with a usable pool and stride first passes through the
// shared restoring modulo unit, one bit a cycle; a new word is taken only once the last is done
// reset: synchronous, active low; the row store needs no clearing pass
module streaming_max_pooling_2d_top #(
    parameter int MAX_WIDTH  = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mp2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_POOL   = mp2d_pkg::DEF_MAX_POOL
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [mp2d_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mp2d_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [mp2d_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mp2d_pkg::SAMPLE_W-1:0] o_pooled_max,
    output logic                                o_frame_last
);
    import mp2d_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CR_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_W  = (CR_W > POOL_W) ? CR_W : POOL_W;
    localparam int STEP_W = $clog2(CNT_W);
    localparam int SLOT_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_POOL;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AX_W   = ADDR_W + 1;
    localparam int CX_W   = CNT_W + POOL_W + 1;
    localparam int REM_W  = POOL_W;
    localparam int REMX_W = POOL_W + 1;

    t_state r_state, n_state;

    logic [IW_W-1:0]     r_image_width;
    logic [IH_W-1:0]     r_image_height;
    logic [POOL_W-1:0]   r_pool;
    logic [STRIDE_W-1:0] r_stride;
    logic                r_dirty;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [REM_W-1:0]  r_col_mod_s;
    logic [REM_W-1:0]  r_row_mod_s;
    logic [SLOT_W-1:0] r_row_mod_p;
    logic [REM_W-1:0]  r_phase;

    logic [SAMPLE_W-1:0] r_sample;

    t_mod_job          r_job;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_dvd;
    logic [REM_W-1:0]  r_rem;

    logic [COL_W-1:0]           r_base_col;
    logic                       r_last;
    logic [SLOT_W-1:0]          r_scan_slot;
    logic [SLOT_W-1:0]          r_scan_n;
    logic                       r_issue_done;
    logic                       r_rd_pend;
    logic signed [SAMPLE_W-1:0] r_best;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_max;
    logic                       r_out_last;

    logic [COL_W-1:0]    w_last;
    logic [ROW_W-1:0]    h_last;
    logic                usable;
    logic                in_acc;
    logic                out_free;
    logic                hit;
    logic                frame_end;
    logic                col_wrap;
    logic                row_wrap;
    logic [CX_W-1:0]     col_x, row_x, pool_x, stride_x;
    logic [POOL_W-1:0]   divisor;
    logic [REMX_W-1:0]   cand;
    logic [REM_W-1:0]    rem_new;
    logic                mod_last;
    t_mod_job            load_job;
    logic [CNT_W-1:0]    load_op;
    logic                n_last, slot_last;
    logic                ram_we, scan_issue, out_load;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    function automatic logic [ADDR_W-1:0] row_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [COL_W-1:0] col);
        logic [AX_W-1:0] full;
        full = AX_W'(slot) * AX_W'(MAX_WIDTH) + AX_W'(col);
        return full[ADDR_W-1:0];
    endfunction

    // effective frame size
    always_comb begin
        if (r_image_width == '0) begin
            w_last = '0;
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(r_image_width - IW_W'(1));
        end
        if (r_image_height == '0) begin
            h_last = '0;
        end else if (int'(r_image_height) > MAX_HEIGHT) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(r_image_height - IH_W'(1));
        end
    end

    assign usable = (r_pool != '0) && (int'(r_pool) <= MAX_POOL) && (r_stride != '0);
    assign in_acc = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // window detection
    assign col_x    = CX_W'(r_col);
    assign row_x    = CX_W'(r_row);
    assign pool_x   = CX_W'(r_pool);
    assign stride_x = CX_W'(r_stride);

    assign hit = usable && (col_x + CX_W'(1) >= pool_x) && (row_x + CX_W'(1) >= pool_x)
              && (r_col <= w_last) && (r_row <= h_last)
              && (r_col_mod_s == r_phase) && (r_row_mod_s == r_phase);
    assign frame_end = (col_x + stride_x > CX_W'(w_last)) && (row_x + stride_x > CX_W'(h_last));
    assign col_wrap = r_col >= w_last;
    assign row_wrap = r_row >= h_last;

    // shared restoring modulo unit
    assign divisor  = (r_job == JOB_ROW_P) ? r_pool : r_stride;
    assign cand     = {r_rem, r_dvd[CNT_W-1]};
    assign rem_new  = (cand >= REMX_W'(divisor)) ? REM_W'(cand - REMX_W'(divisor))
                                                 : REM_W'(cand);
    assign mod_last = r_step == STEP_W'(CNT_W - 1);

    always_comb begin
        if (r_state == ST_IDLE) begin
            load_job = JOB_COL_S;
        end else begin
            case (r_job)
                JOB_COL_S: load_job = JOB_ROW_S;
                JOB_ROW_S: load_job = JOB_ROW_P;
                default:   load_job = JOB_PHASE;
            endcase
        end
        case (load_job)
            JOB_COL_S: load_op = CNT_W'(r_col);
            JOB_ROW_S: load_op = CNT_W'(r_row);
            JOB_ROW_P: load_op = CNT_W'(r_row);
            default:   load_op = CNT_W'(r_pool - POOL_W'(1));
        endcase
    end

    // scan position
    assign n_last    = REMX_W'(r_scan_n) + REMX_W'(1) >= REMX_W'(r_pool);
    assign slot_last = REMX_W'(r_scan_slot) + REMX_W'(1) >= REMX_W'(r_pool);
    assign waddr     = row_addr(r_row_mod_p, r_col);
    assign raddr     = row_addr(r_scan_slot, r_base_col + COL_W'(r_scan_n));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (r_dirty && usable) ? ST_MOD : ST_WRITE;
                end
            end
            ST_MOD: begin
                if (mod_last && r_job == JOB_PHASE) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = hit ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (r_issue_done && !r_rd_pend) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_stall    = 1'b1;
        ram_we     = 1'b0;
        scan_issue = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_stall = 1'b0;
            ST_MOD:   o_stall = 1'b1;
            ST_WRITE: ram_we = usable;
            ST_SCAN:  scan_issue = !r_issue_done;
            ST_EMIT:  out_load = out_free;
            default:  o_stall = 1'b1;
        endcase
    end

    mp2d_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_row_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(r_sample),
        .i_re   (scan_issue),
        .i_raddr(raddr),
        .o_rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_image_width  <= IW_W'(RST_IMAGE_WIDTH);
            r_image_height <= IH_W'(RST_IMAGE_HEIGHT);
            r_pool         <= POOL_W'(RST_POOL_SIZE);
            r_stride       <= STRIDE_W'(RST_STRIDE);
            r_dirty        <= 1'b0;
            r_col          <= '0;
            r_row          <= '0;
            r_col_mod_s    <= '0;
            r_row_mod_s    <= '0;
            r_row_mod_p    <= '0;
            r_phase        <= REM_W'(RST_PHASE);
            r_job          <= JOB_COL_S;
            r_issue_done   <= 1'b0;
            r_rd_pend      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= scan_issue;

            if (r_state == ST_MOD) begin
                if (mod_last) begin
                    case (r_job)
                        JOB_COL_S: r_col_mod_s <= rem_new;
                        JOB_ROW_S: r_row_mod_s <= rem_new;
                        JOB_ROW_P: r_row_mod_p <= SLOT_W'(rem_new);
                        default:   r_phase <= rem_new;
                    endcase
                    if (r_job == JOB_PHASE) begin
                        r_dirty <= 1'b0;
                    end else begin
                        r_job <= load_job;
                    end
                end
            end else if (in_acc) begin
                r_job <= load_job;
            end

            if (r_state == ST_WRITE) begin
                r_issue_done <= 1'b0;
                if (col_wrap) begin
                    r_col       <= '0;
                    r_col_mod_s <= '0;
                    if (row_wrap) begin
                        r_row       <= '0;
                        r_row_mod_s <= '0;
                        r_row_mod_p <= '0;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                        r_row_mod_s <= (REMX_W'(r_row_mod_s) + REMX_W'(1) >= REMX_W'(r_stride))
                                       ? '0 : r_row_mod_s + REM_W'(1);
                        r_row_mod_p <= (REMX_W'(r_row_mod_p) + REMX_W'(1) >= REMX_W'(r_pool))
                                       ? '0 : r_row_mod_p + SLOT_W'(1);
                    end
                end else begin
                    r_col <= r_col + COL_W'(1);
                    r_col_mod_s <= (REMX_W'(r_col_mod_s) + REMX_W'(1) >= REMX_W'(r_stride))
                                   ? '0 : r_col_mod_s + REM_W'(1);
                end
            end

            if (scan_issue && n_last && slot_last) begin
                r_issue_done <= 1'b1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                r_dirty <= 1'b1;
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_wdata[IW_W-1:0];
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata[IH_W-1:0];
                    REG_POOL_SIZE:    r_pool         <= i_cfg_wdata[POOL_W-1:0];
                    REG_STRIDE:       r_stride       <= i_cfg_wdata[STRIDE_W-1:0];
                    default:          r_dirty        <= 1'b1;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample;
        end

        if (in_acc || (r_state == ST_MOD && mod_last)) begin
            r_dvd  <= load_op;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == ST_MOD) begin
            r_dvd  <= {r_dvd[CNT_W-2:0], 1'b0};
            r_rem  <= rem_new;
            r_step <= r_step + STEP_W'(1);
        end

        if (r_state == ST_WRITE) begin
            r_base_col  <= COL_W'(col_x + CX_W'(1) - pool_x);
            r_last      <= frame_end;
            r_scan_slot <= '0;
            r_scan_n    <= '0;
            r_best      <= {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            if (scan_issue) begin
                if (n_last) begin
                    r_scan_n    <= '0;
                    r_scan_slot <= r_scan_slot + SLOT_W'(1);
                end else begin
                    r_scan_n <= r_scan_n + SLOT_W'(1);
                end
            end
            if (r_rd_pend && ($signed(ram_rdata) > r_best)) begin
                r_best <= $signed(ram_rdata);
            end
        end

        if (out_load) begin
            r_out_max  <= r_best;
            r_out_last <= r_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pooled_max = r_out_max;
    assign o_frame_last = r_out_last;

endmodule

### hw/rtl/mp2d_checker.sv
// port level checks for the max pooling top level, attached by bind
// depends on mp2d_pkg and assert_macros.svh
`include "assert_macros.svh"

module mp2d_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [mp2d_pkg::SAMPLE_W-1:0] o_pooled_max,
    input logic                                o_frame_last
);
    import mp2d_pkg::*;

    // a stalled output word holds
    `MP2D_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall |=> o_valid && $stable(o_pooled_max) && $stable(o_frame_last),
        "output word changed under stall")

    // each accepted word raises the input stall before another word can be taken
    `MP2D_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall,
        "input accepted on consecutive cycles")

    // a new result is only loaded while the block is busy
    `MP2D_ASSERT(a_result_from_busy, i_clk, i_rst_n, $rose(o_valid) |-> $past(o_stall),
        "result appeared while idle")

    // reset drops the output word
    `MP2D_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind streaming_max_pooling_2d_top mp2d_checker u_mp2d_checker (.*);

### tb/sv/streaming_max_pooling_2d_top_tb.sv
// self-checking testbench for streaming_max_pooling_2d_top: drives frames under many
// window settings, predicts each pooled word in a scoreboard class and checks it on the fly
// depends on mp2d_pkg and streaming_max_pooling_2d_top
`timescale 1ns / 1ps

module streaming_max_pooling_2d_top_tb;
    import mp2d_pkg::*;

    localparam int LATENCY_WAIT   = 120;
    localparam int RANDOM_SAMPLES = 850;
    localparam int HOLD_CYCLES    = 400;
    localparam int STORE_DEPTH    = DEF_MAX_WIDTH * DEF_MAX_POOL;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] pooled_max;
        logic                       frame_last;
    } t_pooled_word;

    class pool_scoreboard;
        logic [IW_W-1:0]            image_width;
        logic [IH_W-1:0]            image_height;
        logic [POOL_W-1:0]          pool_size;
        logic [STRIDE_W-1:0]        stride;
        int unsigned                col_pos;
        int unsigned                row_pos;
        logic signed [SAMPLE_W-1:0] row_store [STORE_DEPTH];
        t_pooled_word               pending_maxima [$];
        int unsigned                errors;

        function new();
            image_width  = RST_IMAGE_WIDTH;
            image_height = RST_IMAGE_HEIGHT;
            pool_size    = RST_POOL_SIZE;
            stride       = RST_STRIDE;
            col_pos      = 0;
            row_pos      = 0;
            errors       = 0;
            foreach (row_store[a]) row_store[a] = '0;
        endfunction

        function void configure(t_cfg_reg idx, int unsigned value);
            case (idx)
                REG_IMAGE_WIDTH:  image_width  = IW_W'(value);
                REG_IMAGE_HEIGHT: image_height = IH_W'(value);
                REG_POOL_SIZE:    pool_size    = POOL_W'(value);
                REG_STRIDE:       stride       = STRIDE_W'(value);
                default: ;
            endcase
        endfunction

        function void accept_sample(logic signed [SAMPLE_W-1:0] sample);
            int unsigned  w, h, p, s, slot, c, m, n;
            logic signed [SAMPLE_W-1:0] best;
            t_pooled_word word;
            w = (image_width == 0) ? 1 :
                ((image_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : image_width);
            h = (image_height == 0) ? 1 :
                ((image_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : image_height);
            p = pool_size;
            s = stride;
            if (p >= 1 && p <= DEF_MAX_POOL && s >= 1 && col_pos < DEF_MAX_WIDTH) begin
                row_store[(row_pos % p) * DEF_MAX_WIDTH + col_pos] = sample;
                if (col_pos + 1 >= p && row_pos + 1 >= p && col_pos <= w - 1
                        && row_pos <= h - 1 && (col_pos + 1 - p) % s == 0
                        && (row_pos + 1 - p) % s == 0) begin
                    best = {1'b1, {(SAMPLE_W-1){1'b0}}};
                    for (m = 0; m < p; m++) begin
                        slot = (row_pos + 1 + m) % p;
                        for (n = 0; n < p; n++) begin
                            c = col_pos + 1 - p + n;
                            if (row_store[slot * DEF_MAX_WIDTH + c] > best)
                                best = row_store[slot * DEF_MAX_WIDTH + c];
                        end
                    end
                    word.pooled_max = best;
                    word.frame_last = (col_pos + s > w - 1) && (row_pos + s > h - 1);
                    pending_maxima.push_back(word);
                end
            end
            if (col_pos >= w - 1) begin
                col_pos = 0;
                row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        function void compare_pooled(logic signed [SAMPLE_W-1:0] pooled_max, logic frame_last);
            t_pooled_word want;
            if (pending_maxima.size() == 0) begin
                $error("unexpected word: pooled_max %0d frame_last %0b", pooled_max, frame_last);
                errors++;
                return;
            end
            want = pending_maxima.pop_front();
            if (pooled_max !== want.pooled_max) begin
                $error("pooled_max: expected %0d, actual %0d", want.pooled_max, pooled_max);
                errors++;
            end
            if (frame_last !== want.frame_last) begin
                $error("frame_last: expected %0b, actual %0b", want.frame_last, frame_last);
                errors++;
            end
        endfunction

        function int unsigned waiting();
            return pending_maxima.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_wr_en;
    t_cfg_reg                   i_cfg_index;
    logic [CFG_W-1:0]           i_cfg_wdata;
    logic                       i_valid;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [SAMPLE_W-1:0] o_pooled_max;
    logic                       o_frame_last;

    pool_scoreboard sb;
    int unsigned    samples_sent;
    bit             tx_steady;
    bit             hold_off_req;

    streaming_max_pooling_2d_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pooled_max (o_pooled_max),
        .o_frame_last (o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 16'sh7fff;
        if (pick == 1) return 16'sh8000;
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= value;
        do @(posedge i_clk); while (o_stall);
        sb.accept_sample(value);
        samples_sent++;
    endtask

    task automatic set_config(input int unsigned width, height, pool, stride_v);
        int unsigned vals [4];
        int          k;
        vals[REG_IMAGE_WIDTH]  = width;
        vals[REG_IMAGE_HEIGHT] = height;
        vals[REG_POOL_SIZE]    = pool;
        vals[REG_STRIDE]       = stride_v;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        for (k = 0; k < 4; k++) begin
            i_cfg_index <= t_cfg_reg'(k);
            i_cfg_wdata <= CFG_W'(vals[k]);
            sb.configure(t_cfg_reg'(k), vals[k]);
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // frames run until the predicted counters wrap, so a partial frame is finished first
    task automatic run_frames(input int unsigned width, height, pool, stride_v, frames);
        set_config(width, height, pool, stride_v);
        tx_steady = ($urandom_range(0, 3) == 0);
        repeat (frames) begin
            do send_sample(rand_sample()); while (sb.col_pos != 0 || sb.row_pos != 0);
        end
        i_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.compare_pooled(o_pooled_max, o_frame_last);
    end

    initial begin : receiver
        int unsigned pause;
        int unsigned taken;
        bit          rx_steady;
        i_stall <= 1'b1;
        taken = 0;
        rx_steady = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (taken % 48 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
            pause = rx_steady ? 0 : $urandom_range(0, 14);
            if (pause > 0) begin
                i_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    initial begin : stimulus
        int          corner_frame [16];
        int unsigned random_start;
        int unsigned pick, width, height, pool, stride_v;
        int          k;
        sb = new();
        samples_sent = 0;
        tx_steady = 1'b0;
        hold_off_req = 1'b0;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_wdata <= '0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, stopped mid-row, then shrunk below the current column and row
        for (k = 0; k < 138; k++) send_sample(rand_sample());
        i_valid <= 1'b0;
        run_frames(4, 2, 2, 2, 1);

        corner_frame = '{-32768, -32768, 32767, -1,
                         -32768, -32768, 0, 1,
                         21845, -21846, -2, -32767,
                         100, 256, -1, -32768};
        set_config(4, 4, 2, 2);
        for (k = 0; k < 16; k++) send_sample(SAMPLE_W'(corner_frame[k]));
        i_valid <= 1'b0;

        run_frames(1, 1, 1, 1, 2);
        run_frames(0, 3, 1, 1, 1);
        run_frames(3, 0, 1, 2, 1);
        run_frames(3, 2, 0, 1, 1);
        run_frames(3, 2, 9, 1, 1);
        run_frames(3, 2, 15, 1, 1);
        run_frames(4, 4, 2, 0, 1);
        run_frames(3, 3, 4, 1, 1);
        run_frames(8, 8, 8, 15, 1);
        run_frames(9, 9, 8, 1, 1);
        run_frames(511, 1, 1, 8, 1);
        run_frames(256, 1, 1, 3, 1);
        hold_off_req = 1'b1;
        run_frames(0, 2047, 1, 1, 1);

        random_start = samples_sent;
        while (samples_sent - random_start < RANDOM_SAMPLES) begin
            pick = $urandom_range(0, 15);
            if (pick < 11)
                pool = $urandom_range(1, 4);
            else if (pick < 14)
                pool = $urandom_range(5, DEF_MAX_POOL);
            else if (pick == 14)
                pool = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(DEF_MAX_POOL + 1, 15);
            else
                pool = $urandom_range(0, 15);
            pick = $urandom_range(0, 15);
            if (pick < 12)
                stride_v = $urandom_range(1, 4);
            else if (pick < 15)
                stride_v = $urandom_range(5, 8);
            else
                stride_v = $urandom_range(0, 15);
            width  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            height = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            if ($urandom_range(0, 3) != 0) begin
                if (width < pool) width = pool;
                if (height < pool) height = pool;
            end
            if (width * height > 200) height = 200 / width;
            run_frames(width, height, pool, stride_v, $urandom_range(1, 3));
        end

        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("streaming_max_pooling_2d_top test passed");
        end else begin
            $display("streaming_max_pooling_2d_top test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(40_000_000);
        $display("streaming_max_pooling_2d_top test failed");
        $finish;
    end

endmodule
